/* rtl/ready_queue_with_removal_top_macros.svh */
// ----------------------------------------------------------------------------
// Ready queue assertion macros
// Short forms of the concurrent assertions used by the queue top level.
// ----------------------------------------------------------------------------
`ifndef READY_QUEUE_WITH_REMOVAL_TOP_MACROS_SVH
`define READY_QUEUE_WITH_REMOVAL_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RQR_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RQR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/rqr_pkg.sv */
// ----------------------------------------------------------------------------
// Ready queue package
// Sizes, operation and status codes, and the control word for the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package rqr_pkg;

   localparam int QUEUE_DEPTH    = 16;
   localparam int ID_BITS        = 8;
   localparam int ENTRY_ID_WIDTH = 8;
   localparam int KIND_WIDTH     = 3;
   localparam int STATUS_WIDTH   = 2;
   localparam int COUNT_BITS     = $clog2(QUEUE_DEPTH + 1);

   typedef logic [ID_BITS-1:0]    id_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_PUSH_TAIL = 3'd0,
      KIND_PUSH_HEAD = 3'd1,
      KIND_REMOVE    = 3'd2,
      KIND_POP       = 3'd3,
      KIND_PEEK      = 3'd4
   } kind_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // What every cell does in the coming cycle.
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_APPEND,
      CELL_SHIFT_IN,
      CELL_REMOVE,
      CELL_SHIFT_OUT
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      id_type      key;
   } cell_ctrl_type;

endpackage

`default_nettype wire

/* rtl/rqr_chan_if.sv */
// ----------------------------------------------------------------------------
// Ready queue channels
// Request and response channel interfaces with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface rqr_req_if;
   import rqr_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [KIND_WIDTH-1:0]     kind;
   logic [ENTRY_ID_WIDTH-1:0] entry_id;

   modport source (output valid, output kind, output entry_id, input ready);
   modport sink (input valid, input kind, input entry_id, output ready);
endinterface

interface rqr_rsp_if;
   import rqr_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [STATUS_WIDTH-1:0]   status;
   logic [ENTRY_ID_WIDTH-1:0] head_id;
   logic                      head_valid;
   logic [COUNT_BITS-1:0]     occupancy;

   modport source (output valid, output status, output head_id, output head_valid,
                   output occupancy, input ready);
   modport sink (input valid, input status, input head_id, input head_valid,
                 input occupancy, output ready);
endinterface

`default_nettype wire

/* rtl/rqr_cell.sv */
// ----------------------------------------------------------------------------
// Ready queue cell
// One queue slot; loads from its neighbors and flags a match with the key.
// ----------------------------------------------------------------------------
`default_nettype none

module rqr_cell (
   input  logic                  clock,
   input  rqr_pkg::cell_ctrl_type ctrl,
   input  logic                  occupied,
   input  logic                  is_tail,
   input  rqr_pkg::id_type       left_id,
   input  rqr_pkg::id_type       right_id,
   input  logic                  match_in,
   output logic                  match_out,
   output rqr_pkg::id_type       id_out
);
   import rqr_pkg::*;

   id_type id_ff;
   id_type id_in;

   // A match here or anywhere nearer the head moves this slot during a removal.
   assign match_out = match_in || (occupied && (id_ff == ctrl.key));
   assign id_out    = id_ff;

   always_comb begin
      id_in = id_ff;
      unique case (ctrl.op)
         CELL_APPEND: begin
            if (is_tail) begin
               id_in = ctrl.key;
            end
         end
         CELL_SHIFT_IN:  id_in = left_id;
         CELL_REMOVE: begin
            if (match_out) begin
               id_in = right_id;
            end
         end
         CELL_SHIFT_OUT: id_in = right_id;
         default:        id_in = id_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
   end

endmodule

`default_nettype wire

/* rtl/ready_queue_with_removal_top.sv */
// ----------------------------------------------------------------------------
// Ready queue with removal by identifier
// Bounded deque of task identifiers held in a row of shifting cells.
// ----------------------------------------------------------------------------
//
//   Channel    Dir  Handshake     Word contents
//   req_chan   in   valid/ready   kind, entry_id
//   rsp_chan   out  valid/ready   status, head_id, head_valid, occupancy
//
// Every accepted request word is executed in the cycle it is accepted, so the
// block sustains one word per cycle while rsp_chan.ready stays high; the row
// of cells compares and shifts all slots in that same cycle. The response
// word is registered and appears in the following cycle. Reset (synchronous,
// active high) empties the queue and drops any pending response; no request
// is taken while reset is high. Slot contents are not cleared since slots
// beyond the count are never read. While a response waits for rsp_chan.ready,
// a new request is taken only if that response leaves in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ready_queue_with_removal_top_macros.svh"

module ready_queue_with_removal_top (
   input  logic      clock,
   input  logic      reset,
   rqr_req_if.sink   req_chan,
   rqr_rsp_if.source rsp_chan
);
   import rqr_pkg::*;

   // Queue state: the count lives here, the identifiers live in the cells.
   count_type     count_ff;
   count_type     count_in;
   id_type        ids [QUEUE_DEPTH];
   logic          match_chain [QUEUE_DEPTH+1];
   cell_op_type   cell_op;
   cell_ctrl_type ctrl;

   // Response register.
   logic                      rsp_valid_ff;
   status_type                status_ff;
   status_type                status_in;
   logic [ENTRY_ID_WIDTH-1:0] head_id_ff;
   logic [ENTRY_ID_WIDTH-1:0] head_id_in;
   logic                      head_valid_ff;
   logic                      head_valid_in;
   count_type                 occupancy_ff;

   logic     accept;
   kind_type kind;
   logic     full;
   logic     empty;
   logic     found;

   // A request is taken when the response register is free or emptying now.
   assign req_chan.ready = !reset && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;

   assign kind  = kind_type'(req_chan.kind);
   assign ctrl  = '{op: cell_op, key: req_chan.entry_id[ID_BITS-1:0]};
   assign full  = (count_ff == COUNT_BITS'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);

   // The match chain runs from the head; its far end says whether any
   // occupied slot holds the key.
   assign match_chain[0] = 1'b0;
   assign found          = match_chain[QUEUE_DEPTH];

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      id_type left_id;
      id_type right_id;

      if (i == 0) begin : g_head
         assign left_id = ctrl.key;
      end else begin : g_body
         assign left_id = ids[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right_id = ids[i];
      end else begin : g_inner
         assign right_id = ids[i+1];
      end

      rqr_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .occupied  (COUNT_BITS'(i) < count_ff),
         .is_tail   (COUNT_BITS'(i) == count_ff),
         .left_id   (left_id),
         .right_id  (right_id),
         .match_in  (match_chain[i]),
         .match_out (match_chain[i+1]),
         .id_out    (ids[i])
      );
   end

   // Decode the request into a cell command, a new count and a response.
   // Refused requests leave the cells holding and the count unchanged.
   always_comb begin
      cell_op       = CELL_HOLD;
      count_in      = count_ff;
      status_in     = ST_OK;
      head_id_in    = '0;
      head_valid_in = 1'b0;
      unique case (kind)
         KIND_PUSH_TAIL, KIND_PUSH_HEAD: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               cell_op  = (kind == KIND_PUSH_TAIL) ? CELL_APPEND : CELL_SHIFT_IN;
               count_in = count_ff + count_type'(1);
            end
         end
         KIND_REMOVE: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else if (!found) begin
               status_in = ST_NOT_FOUND;
            end else begin
               cell_op  = CELL_REMOVE;
               count_in = count_ff - count_type'(1);
            end
         end
         KIND_POP, KIND_PEEK: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               head_id_in    = ENTRY_ID_WIDTH'(ids[0]);
               head_valid_in = 1'b1;
               if (kind == KIND_POP) begin
                  cell_op  = CELL_SHIFT_OUT;
                  count_in = count_ff - count_type'(1);
               end
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
      if (!accept) begin
         cell_op  = CELL_HOLD;
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Response payload is loaded with every accepted word.
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff     <= status_in;
         head_id_ff    <= head_id_in;
         head_valid_ff <= head_valid_in;
         occupancy_ff  <= count_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = status_ff;
   assign rsp_chan.head_id    = head_id_ff;
   assign rsp_chan.head_valid = head_valid_ff;
   assign rsp_chan.occupancy  = occupancy_ff;

   // The count must never pass the depth.
   `RQR_ASSERT_SAME(a_count_bound, clock, reset, 1'b1,
      count_ff <= COUNT_BITS'(QUEUE_DEPTH), "queue count beyond depth")

   // Every accepted word leaves a response pending in the next cycle.
   `RQR_ASSERT_NEXT(a_rsp_follows, clock, reset, accept,
      rsp_valid_ff && occupancy_ff == count_ff, "response missing after accept")

   // A successful pop returns the old head and shrinks the queue by one.
   `RQR_ASSERT_NEXT(a_pop_head, clock, reset, accept && kind == KIND_POP && !empty,
      head_id_ff == ENTRY_ID_WIDTH'($past(ids[0])) && count_ff == $past(count_ff) - count_type'(1),
      "pop returned wrong head or count")

endmodule

`default_nettype wire

/* verif/ready_queue_with_removal_top_test.sv */
// ----------------------------------------------------------------------------
// Ready queue with removal: self-checking testbench
// Drives queue operation words into the block and checks every response word
// against a deque model of the queue kept inside the testbench.
// ----------------------------------------------------------------------------
`default_nettype none

module ready_queue_with_removal_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import rqr_pkg::*;

   // Kinds 5 to 7 carry no operation. The block must answer them with an ok
   // status and leave the queue alone.
   localparam logic [KIND_WIDTH-1:0] KIND_UNUSED_LO  = 3'd5;
   localparam logic [KIND_WIDTH-1:0] KIND_UNUSED_MID = 3'd6;
   localparam logic [KIND_WIDTH-1:0] KIND_UNUSED_HI  = 3'd7;

   // Stimulus shapes. Fill bursts drive the queue up to full, drain bursts
   // drive it back down to empty, and mixed bursts wander in between.
   localparam int MODE_FILL  = 0;
   localparam int MODE_DRAIN = 1;
   localparam int MODE_MIXED = 2;

   localparam int PHASE_WORDS = 345;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 10;

   typedef struct {
      logic [KIND_WIDTH-1:0]     kind;
      logic [ENTRY_ID_WIDTH-1:0] entry_id;
   } queue_req_type;

   typedef struct {
      status_type                status;
      logic [ENTRY_ID_WIDTH-1:0] head_id;
      logic                      head_valid;
      logic [COUNT_BITS-1:0]     occupancy;
   } queue_rsp_type;

   logic clock;
   logic reset;

   rqr_req_if req_bus ();
   rqr_rsp_if rsp_bus ();

   ready_queue_with_removal_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Words waiting to be offered on the request channel, the model's copy of
   // the queue contents (head at index 0), and the responses still owed.
   queue_req_type request_backlog[$];
   id_type        queued_ids[$];
   queue_rsp_type awaited_rsps[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int error_count    = 0;
   int words_accepted = 0;
   int rsps_checked   = 0;
   int peak_occupancy = 0;
   int status_hits[4] = '{0, 0, 0, 0};
   int cycle_count    = 0;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Apply one operation to the model queue and return the response word
   // that the block owes for it.
   function automatic queue_rsp_type apply_queue_op(input logic [KIND_WIDTH-1:0] kind,
                                                    input logic [ENTRY_ID_WIDTH-1:0] raw_id);
      queue_rsp_type rsp;
      id_type        id;
      int            pos;
      rsp.status     = ST_OK;
      rsp.head_id    = '0;
      rsp.head_valid = 1'b0;
      id  = raw_id[ID_BITS-1:0];
      pos = -1;
      case (kind)
         KIND_PUSH_TAIL, KIND_PUSH_HEAD: begin
            if (queued_ids.size() >= QUEUE_DEPTH) begin
               rsp.status = ST_FULL;
            end else if (kind == KIND_PUSH_TAIL) begin
               queued_ids.push_back(id);
            end else begin
               queued_ids.push_front(id);
            end
         end
         KIND_REMOVE: begin
            if (queued_ids.size() == 0) begin
               rsp.status = ST_EMPTY;
            end else begin
               // Duplicates are legal; the one nearest the head goes.
               for (int i = 0; i < queued_ids.size() && pos < 0; i++) begin
                  if (queued_ids[i] == id) pos = i;
               end
               if (pos < 0) begin
                  rsp.status = ST_NOT_FOUND;
               end else begin
                  queued_ids.delete(pos);
               end
            end
         end
         KIND_POP, KIND_PEEK: begin
            if (queued_ids.size() == 0) begin
               rsp.status = ST_EMPTY;
            end else begin
               rsp.head_id    = queued_ids[0];
               rsp.head_valid = 1'b1;
               if (kind == KIND_POP) void'(queued_ids.pop_front());
            end
         end
         default: begin
         end
      endcase
      rsp.occupancy = COUNT_BITS'(queued_ids.size());
      return rsp;
   endfunction

   // Identifiers come mostly from a small pool so that removes find their
   // target and duplicates build up; the rest spans the whole field.
   function automatic logic [ENTRY_ID_WIDTH-1:0] pick_id();
      if ($urandom_range(99) < 70) return ENTRY_ID_WIDTH'($urandom_range(7));
      return ENTRY_ID_WIDTH'($urandom_range(255));
   endfunction

   function automatic queue_req_type make_word(input int mode);
      queue_req_type word;
      int            roll;
      roll = $urandom_range(99);
      word.entry_id = pick_id();
      if (roll < 4) begin
         word.kind = KIND_WIDTH'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO));
      end else if (mode == MODE_FILL) begin
         word.kind = (roll < 50) ? KIND_PUSH_TAIL : (roll < 75) ? KIND_PUSH_HEAD :
                     (roll < 85) ? KIND_REMOVE : (roll < 93) ? KIND_POP : KIND_PEEK;
      end else if (mode == MODE_DRAIN) begin
         word.kind = (roll < 12) ? KIND_PUSH_TAIL : (roll < 20) ? KIND_PUSH_HEAD :
                     (roll < 50) ? KIND_REMOVE : (roll < 88) ? KIND_POP : KIND_PEEK;
      end else begin
         word.kind = (roll < 24) ? KIND_PUSH_TAIL : (roll < 43) ? KIND_PUSH_HEAD :
                     (roll < 62) ? KIND_REMOVE : (roll < 81) ? KIND_POP : KIND_PEEK;
      end
      return word;
   endfunction

   task automatic queue_word(input logic [KIND_WIDTH-1:0] kind,
                             input logic [ENTRY_ID_WIDTH-1:0] entry_id);
      queue_req_type word;
      word.kind     = kind;
      word.entry_id = entry_id;
      request_backlog.push_back(word);
   endtask

   // Fill the backlog with one phase of random bursts.
   task automatic queue_random_phase(input int words);
      int mode;
      int burst;
      while (words > 0) begin
         mode  = $urandom_range(MODE_MIXED, MODE_FILL);
         burst = $urandom_range(48, 24);
         if (burst > words) burst = words;
         repeat (burst) request_backlog.push_back(make_word(mode));
         words -= burst;
      end
   endtask

   // Block until every queued word has been accepted and answered.
   task automatic drain_all();
      while (request_backlog.size() != 0 || awaited_rsps.size() != 0 || req_bus.valid)
         @(negedge clock);
   endtask

   task automatic check_field(input string field, input int expected_val,
                              input logic [7:0] actual_val);
      if (actual_val !== expected_val[7:0]) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h",
                  $time, field, expected_val, actual_val);
      end
   endtask

   // Request driver. A word on the bus is held until it is taken; at the edge
   // that takes it, the model applies the operation and the owed response is
   // recorded. Only then may the next word, or an idle cycle, be put up.
   always @(posedge clock) begin : request_driver
      queue_req_type next_word;
      queue_rsp_type owed;
      if (reset) begin
         req_bus.valid    <= 1'b0;
         req_bus.kind     <= '0;
         req_bus.entry_id <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            owed = apply_queue_op(req_bus.kind, req_bus.entry_id);
            awaited_rsps.push_back(owed);
            words_accepted++;
            status_hits[owed.status]++;
            if (int'(owed.occupancy) > peak_occupancy) peak_occupancy = int'(owed.occupancy);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_word = request_backlog.pop_front();
               req_bus.valid    <= 1'b1;
               req_bus.kind     <= next_word.kind;
               req_bus.entry_id <= next_word.entry_id;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor. Each word taken off the response channel is compared
   // field by field with the oldest owed response. The ready it drives is
   // re-rolled every cycle so that stalls land on every point of the flow.
   always @(posedge clock) begin : response_monitor
      queue_rsp_type owed;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_rsps.size() == 0) begin
               error_count++;
               $display("%0t: unexpected response word, expected none, actual %0h/%0h/%0h/%0h",
                        $time, rsp_bus.status, rsp_bus.head_id, rsp_bus.head_valid,
                        rsp_bus.occupancy);
            end else begin
               owed = awaited_rsps.pop_front();
               check_field("status", int'(owed.status), 8'(rsp_bus.status));
               check_field("head_id", int'(owed.head_id), rsp_bus.head_id);
               check_field("head_valid", int'(owed.head_valid), 8'(rsp_bus.head_valid));
               check_field("occupancy", int'(owed.occupancy), 8'(rsp_bus.occupancy));
               rsps_checked++;
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: a hung handshake must not run forever.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses still owed.",
                  cycle_count, awaited_rsps.size());
         $display("FAIL ready_queue_with_removal_top");
         $finish;
      end
   end

   initial begin
      // Everything the block sees is known from time zero.
      req_bus.valid    = 1'b0;
      req_bus.kind     = '0;
      req_bus.entry_id = '0;
      rsp_bus.ready    = 1'b0;
      reset            = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed opening, no idling. An empty queue must refuse pop, peek
      // and remove; unused kinds are no-ops; the extreme identifiers round
      // trip; a duplicate is removed from the head side; a missing id is
      // reported; and the queue is drained back to empty.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      queue_word(KIND_PEEK, 8'h00);
      queue_word(KIND_POP, 8'hFF);
      queue_word(KIND_REMOVE, 8'hFF);
      queue_word(KIND_UNUSED_LO, 8'h12);
      queue_word(KIND_UNUSED_MID, 8'h34);
      queue_word(KIND_UNUSED_HI, 8'hFF);
      queue_word(KIND_PUSH_TAIL, 8'h00);
      queue_word(KIND_PUSH_HEAD, 8'hFF);
      queue_word(KIND_PUSH_TAIL, 8'h5A);
      queue_word(KIND_PUSH_TAIL, 8'h00);
      queue_word(KIND_UNUSED_LO, 8'hA5);
      queue_word(KIND_REMOVE, 8'h00);
      queue_word(KIND_REMOVE, 8'h33);
      queue_word(KIND_PEEK, 8'h77);
      queue_word(KIND_POP, 8'h00);
      queue_word(KIND_POP, 8'h00);
      queue_word(KIND_POP, 8'h00);
      queue_word(KIND_POP, 8'h00);
      queue_random_phase(PHASE_WORDS);
      drain_all();

      // Sender leaves half of the cycles idle.
      send_idle_pct = 50;
      queue_random_phase(PHASE_WORDS);
      drain_all();

      // Receiver stalls half of the cycles, so responses back up onto the
      // request side.
      send_idle_pct  = 0;
      recv_stall_pct = 50;
      queue_random_phase(PHASE_WORDS);
      drain_all();

      // Both sides hesitate.
      send_idle_pct  = 29;
      recv_stall_pct = 29;
      queue_random_phase(PHASE_WORDS);
      drain_all();

      // Let the block run on idle so that any stray response word shows up.
      recv_stall_pct = 0;
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Ran %0d queue operation words through four pacing phases, %0d responses checked.",
               words_accepted, rsps_checked);
      $display("Statuses seen: ok %0d, empty %0d, full %0d, not found %0d; peak occupancy %0d.",
               status_hits[ST_OK], status_hits[ST_EMPTY], status_hits[ST_FULL],
               status_hits[ST_NOT_FOUND], peak_occupancy);
      if (error_count == 0) begin
         $display("PASS ready_queue_with_removal_top");
      end else begin
         $display("FAIL ready_queue_with_removal_top");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* sim.f */
+incdir+rtl
rtl/rqr_pkg.sv
rtl/rqr_chan_if.sv
rtl/rqr_cell.sv
rtl/ready_queue_with_removal_top.sv
verif/ready_queue_with_removal_top_test.sv
